// ----- design/ittf_pkg.sv -----
// ============================================================================
// ittf_pkg
// Shared constants, types and a helper function of the integer-to-text
// formatter.
// ============================================================================
package ittf_pkg;

    localparam int MAX_DIGITS = 32;
    localparam int MAX_WIDTH  = 64;

    localparam int MAG_W        = 64;
    localparam int NUM_NIB      = (MAG_W + 2) / 3;
    localparam int NIB_IDX_W    = $clog2(NUM_NIB);
    localparam int DIG_VEC_W    = 4 * NUM_NIB;
    localparam int STEP_CNT_W   = $clog2(MAG_W);
    localparam int WIDTH_W      = 7;
    localparam int MIND_W       = 6;
    localparam int LEN_W        = 7;
    localparam int HEX_NIB      = MAG_W / 4;

    localparam logic [MIND_W-1:0]  MIND_CAP  = MIND_W'(MAX_DIGITS);
    localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(MAX_WIDTH);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_MEASURE,
        ST_EMIT
    } ittf_state_t;

    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic               is_negative;
        logic [1:0]         radix_select;
        logic               upper_case;
        logic [WIDTH_W-1:0] field_width;
        logic [MIND_W-1:0]  min_digits;
        logic               left_justify;
        logic               zero_pad;
        logic               alternate_form;
    } ittf_item_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic scan;
        logic measure;
        logic emit;
    } ittf_cmd_t;

    typedef struct packed {
        logic is_dec;
        logic dabble_done;
        logic scan_done;
        logic slot_free;
        logic emit_last;
    } ittf_status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10)
            digit_char = CH_ZERO + {4'b0000, d};
        else
            digit_char = base + {4'b0000, d} - 8'd10;
    endfunction

endpackage

// ----- design/ittf_in_if.sv -----
// ============================================================================
// ittf_in_if
// Input channel of the formatter: one number and its format spec per item.
// ============================================================================
interface ittf_in_if
    import ittf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MAG_W-1:0]   magnitude;
    logic               is_negative;
    logic [1:0]         radix_select;
    logic               upper_case;
    logic [WIDTH_W-1:0] field_width;
    logic [MIND_W-1:0]  min_digits;
    logic               left_justify;
    logic               zero_pad;
    logic               alternate_form;

    modport source (
        output valid, magnitude, is_negative, radix_select, upper_case,
               field_width, min_digits, left_justify, zero_pad, alternate_form,
        input  ready
    );

    modport sink (
        input  valid, magnitude, is_negative, radix_select, upper_case,
               field_width, min_digits, left_justify, zero_pad, alternate_form,
        output ready
    );

    modport monitor (
        input valid, ready, magnitude, is_negative, radix_select, upper_case,
              field_width, min_digits, left_justify, zero_pad, alternate_form
    );
endinterface

// ----- design/ittf_out_if.sv -----
// ============================================================================
// ittf_out_if
// Output channel of the formatter: one character per item.
// ============================================================================
interface ittf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (
        output valid, out_char, last_char,
        input  ready
    );

    modport sink (
        input  valid, out_char, last_char,
        output ready
    );

    modport monitor (
        input valid, ready, out_char, last_char
    );
endinterface

// ----- design/ittf_ctrl.sv -----
// ============================================================================
// ittf_ctrl
// Sequencer of the formatter: load, decimal conversion, digit scan,
// layout measurement and character emission.
// ============================================================================
module ittf_ctrl
    import ittf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  ittf_status_t status,
    output ittf_cmd_t    cmd
);

    ittf_state_t state_reg;
    ittf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                // Octal and hex digits are taken straight from the magnitude.
                if (!status.is_dec)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.dabble = 1'b1;
                    if (status.dabble_done)
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                    state_next = ST_MEASURE;
                else
                    cmd.scan = 1'b1;
            end
            ST_MEASURE:
            begin
                cmd.measure = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/ittf_datapath.sv -----
// ============================================================================
// ittf_datapath
// Digit register, shift-and-add-3 decimal converter, leading digit scan,
// layout arithmetic and the output character register.
// ============================================================================
module ittf_datapath
    import ittf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ittf_item_t   item,
    input  ittf_cmd_t    cmd,
    output ittf_status_t status,
    input  logic         out_ready,
    output logic         out_valid,
    output logic [7:0]   out_char,
    output logic         out_last
);

    logic [DIG_VEC_W-1:0]  dig_reg, dig_next;
    logic [MAG_W-1:0]      mag_reg, mag_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NIB_IDX_W-1:0]  idx_reg, idx_next;

    logic                  neg_reg, upper_reg, left_reg, zero_reg, alt_reg;
    logic [1:0]            radix_reg;
    logic [WIDTH_W-1:0]    width_reg;
    logic [MIND_W-1:0]     mind_reg;

    logic [LEN_W-1:0]      b1_reg, b2_reg, b3_reg, b4_reg, len_reg, pos_reg;
    logic [7:0]            p0_reg, p1_reg, p2_reg;

    logic                  out_valid_reg, out_last_reg;
    logic [7:0]            out_char_reg;

    // Load and conversion of the digit register.
    logic [MAG_W+1:0]      mag_pad;
    logic [1:0]            radix_in;
    logic [DIG_VEC_W-1:0]  load_dig;
    logic [DIG_VEC_W-1:0]  adj_dig;
    logic [3:0]            scan_digit;

    assign mag_pad  = {2'b00, item.magnitude};
    assign radix_in = (item.radix_select == RADIX_OCT) ? RADIX_OCT :
                      (item.radix_select == RADIX_HEX) ? RADIX_HEX : RADIX_DEC;

    always_comb
    begin
        load_dig = '0;
        for (int i = 0; i < NUM_NIB; i++)
        begin
            if (radix_in == RADIX_OCT)
                load_dig[4*i +: 4] = {1'b0, mag_pad[3*i +: 3]};
            else if (radix_in == RADIX_HEX && i < HEX_NIB)
                load_dig[4*i +: 4] = item.magnitude[4*i +: 4];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_NIB; i++)
        begin
            adj_dig[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ? dig_reg[4*i +: 4] + 4'd3
                                                             : dig_reg[4*i +: 4];
        end
    end

    assign scan_digit = dig_reg[{idx_reg, 2'b00} +: 4];

    always_comb
    begin
        dig_next = dig_reg;
        mag_next = mag_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.load)
        begin
            dig_next = load_dig;
            mag_next = item.magnitude;
            cnt_next = '0;
            idx_next = NIB_IDX_W'(NUM_NIB - 1);
        end
        else if (cmd.dabble)
        begin
            dig_next = {adj_dig[DIG_VEC_W-2:0], mag_reg[MAG_W-1]};
            mag_next = {mag_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.scan)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    // Layout of the text: prefix, padding and digit count.
    logic [MIND_W-1:0]  sig_cnt, mind_c, ndig;
    logic               top_nz, is_hex, is_oct, alt_hex, alt_oct;
    logic [1:0]         npre;
    logic [7:0]         xch;
    logic [LEN_W-1:0]   total, wc, pad, m_b1, m_b2, m_b3, m_b4, m_len;

    always_comb
    begin
        sig_cnt = {1'b0, idx_reg} + 1'b1;
        mind_c  = (mind_reg > MIND_CAP) ? MIND_CAP : mind_reg;
        ndig    = (mind_c > sig_cnt) ? mind_c : sig_cnt;
        // The top character is a real digit only when the precision adds no zeros.
        top_nz  = (mind_c <= sig_cnt) && (scan_digit != 4'd0);
        is_hex  = (radix_reg == RADIX_HEX);
        is_oct  = (radix_reg == RADIX_OCT);
        alt_hex = alt_reg && is_hex;
        alt_oct = alt_reg && is_oct && top_nz;
        npre    = {1'b0, neg_reg} + (alt_hex ? 2'd2 : (alt_oct ? 2'd1 : 2'd0));
        xch     = upper_reg ? CH_UX : CH_LX;
        total   = {5'b00000, npre} + {1'b0, ndig};
        wc      = (width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
        pad     = (wc > total) ? wc - total : '0;
        m_b1    = (!left_reg && !zero_reg) ? pad : '0;
        m_b2    = m_b1 + {5'b00000, npre};
        m_b3    = m_b2 + ((!left_reg && zero_reg) ? pad : '0);
        m_b4    = m_b3 + {1'b0, ndig};
        m_len   = m_b4 + (left_reg ? pad : '0);
    end

    // Character at the current output position.
    logic [LEN_W-1:0] pre_off, dig_off;
    logic [3:0]       emit_digit;
    logic [7:0]       emit_ch;
    logic             emit_last;

    always_comb
    begin
        pre_off    = pos_reg - b1_reg;
        dig_off    = b4_reg - pos_reg - 1'b1;
        emit_digit = dig_reg[{dig_off[NIB_IDX_W-1:0], 2'b00} +: 4];
        if (pos_reg < b1_reg)
            emit_ch = CH_SPACE;
        else if (pos_reg < b2_reg)
            emit_ch = (pre_off == '0) ? p0_reg :
                      (pre_off == LEN_W'(1)) ? p1_reg : p2_reg;
        else if (pos_reg < b3_reg)
            emit_ch = CH_ZERO;
        else if (pos_reg < b4_reg)
            emit_ch = (dig_off > {2'b00, idx_reg}) ? CH_ZERO
                                                   : digit_char(emit_digit, upper_reg);
        else
            emit_ch = CH_SPACE;
        emit_last = (pos_reg == len_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        mag_reg <= mag_next;
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            neg_reg   <= item.is_negative;
            radix_reg <= radix_in;
            upper_reg <= item.upper_case;
            width_reg <= item.field_width;
            mind_reg  <= item.min_digits;
            left_reg  <= item.left_justify;
            zero_reg  <= item.zero_pad;
            alt_reg   <= item.alternate_form;
        end
        if (cmd.measure)
        begin
            b1_reg  <= m_b1;
            b2_reg  <= m_b2;
            b3_reg  <= m_b3;
            b4_reg  <= m_b4;
            len_reg <= m_len;
            p0_reg  <= neg_reg ? CH_MINUS : CH_ZERO;
            p1_reg  <= neg_reg ? CH_ZERO : xch;
            p2_reg  <= xch;
            pos_reg <= '0;
        end
        else if (cmd.emit)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            out_char_reg <= emit_ch;
            out_last_reg <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.is_dec      = (radix_reg == RADIX_DEC);
    assign status.dabble_done = (cnt_reg == STEP_CNT_W'(MAG_W - 1));
    assign status.scan_done   = (scan_digit != 4'd0) || (idx_reg == '0);
    assign status.slot_free   = !out_valid_reg || out_ready;
    assign status.emit_last   = emit_last;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- design/integer_to_text_formatter_unit.sv -----
// Octal and hex digits are loaded straight from the magnitude; decimal takes one
// magnitude bit per cycle through the shift-and-add-3 converter. Then follow a leading-digit
// scan, a layout step, and one character per cycle while the receiver keeps up (up to 64).
// One number is in work at a time; a new one is taken once its last character is loaded.
// Reset is asynchronous and active low; it returns the sequencer to idle and empties
// the output register.
// ============================================================================
// integer_to_text_formatter_unit
// Printf-style integer to ASCII text conversion, one character per item.
// ============================================================================
module integer_to_text_formatter_unit
    import ittf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    ittf_in_if.sink   number,
    ittf_out_if.source text
);

    ittf_cmd_t    cmd;
    ittf_status_t status;
    ittf_item_t   item;
    logic         item_ready;

    assign item.magnitude      = number.magnitude;
    assign item.is_negative    = number.is_negative;
    assign item.radix_select   = number.radix_select;
    assign item.upper_case     = number.upper_case;
    assign item.field_width    = number.field_width;
    assign item.min_digits     = number.min_digits;
    assign item.left_justify   = number.left_justify;
    assign item.zero_pad       = number.zero_pad;
    assign item.alternate_form = number.alternate_form;

    assign number.ready = item_ready;

    ittf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (number.valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    ittf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .out_ready (text.ready),
        .out_valid (text.valid),
        .out_char  (text.out_char),
        .out_last  (text.last_char)
    );

endmodule

// ----- design/ittf_checker.sv -----
// ============================================================================
// ittf_checker
// Port-level checks of the formatter, bound to the top level.
// ============================================================================
module ittf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       out_last
);

    // A character that waits for the sink holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char)
                                    && $stable(out_last))
        else $error("output item changed while stalled");

    // Only one number is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an item");

    // While the block is ready, any character still waiting is the final one.
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_last)
        else $error("ready for a new number in the middle of a text");

endmodule

bind integer_to_text_formatter_unit ittf_checker u_ittf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .out_char  (text.out_char),
    .out_last  (text.last_char)
);

// ----- tb/integer_to_text_formatter_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// integer_to_text_formatter_unit_tb
// Self-checking bench for the printf-style integer formatter. A directed table
// covers the field extremes and corner cases, and a random stream follows it.
// Every character is checked against the table text or a predictor, under bursty input
// traffic and a stalling text receiver.
// ============================================================================
module integer_to_text_formatter_unit_tb;
    import ittf_pkg::*;

    localparam logic [1:0] RADIX_UNUSED = 2'd3;
    localparam int         RANDOM_ITEMS = 410;
    localparam int         TAIL_CYCLES  = 200;
    localparam int         REPORT_CAP   = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    typedef struct {
        ittf_item_t spec;
        string      text;
    } number_case_t;

    logic clk;
    logic rst_n;

    ittf_in_if  number_if ();
    ittf_out_if text_if ();

    text_char_t   expected_text[$];
    number_case_t number_cases[$];
    int           mismatch_count;

    integer_to_text_formatter_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_if),
        .text   (text_if)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Builds the formatted text of one number and queues its characters.
    function automatic void format_text(input ittf_item_t spec);
        logic [63:0] value;
        logic [7:0]  digits[72];
        logic [7:0]  prefix[3];
        logic [7:0]  line[256];
        int          radix;
        int          width;
        int          mind;
        int          ndig;
        int          npre;
        int          len;
        int          total;
        int          pad;
        int          n;
        int          d;

        value = spec.magnitude;
        radix = (spec.radix_select == RADIX_OCT) ? 8 :
                (spec.radix_select == RADIX_HEX) ? 16 : 10;
        mind  = int'(spec.min_digits);
        width = int'(spec.field_width);
        if (mind > MAX_DIGITS)
            mind = MAX_DIGITS;
        if (width > MAX_WIDTH)
            width = MAX_WIDTH;

        // Digits are collected least significant first.
        ndig = 0;
        do
        begin
            d = int'(value % 64'(radix));
            digits[ndig] = (d < 10) ? CH_ZERO + 8'(d)
                                    : (spec.upper_case ? CH_UA : CH_LA) + 8'(d - 10);
            ndig = ndig + 1;
            value = value / 64'(radix);
        end
        while (value != 64'd0 && ndig < 64);
        while (ndig < mind && ndig < 64)
        begin
            digits[ndig] = CH_ZERO;
            ndig = ndig + 1;
        end

        npre = 0;
        if (spec.is_negative)
        begin
            prefix[npre] = CH_MINUS;
            npre = npre + 1;
        end
        if (spec.alternate_form && radix == 16)
        begin
            prefix[npre]     = CH_ZERO;
            prefix[npre + 1] = spec.upper_case ? CH_UX : CH_LX;
            npre = npre + 2;
        end
        else if (spec.alternate_form && radix == 8 && digits[ndig - 1] != CH_ZERO)
        begin
            prefix[npre] = CH_ZERO;
            npre = npre + 1;
        end

        total = npre + ndig;
        pad   = (width > total) ? width - total : 0;
        len   = 0;
        if (!spec.left_justify && !spec.zero_pad)
            for (int k = 0; k < pad; k++)
                line[len++] = CH_SPACE;
        for (int k = 0; k < npre; k++)
            line[len++] = prefix[k];
        if (!spec.left_justify && spec.zero_pad)
            for (int k = 0; k < pad; k++)
                line[len++] = CH_ZERO;
        for (int k = ndig; k != 0; k--)
            line[len++] = digits[k - 1];
        if (spec.left_justify)
            for (int k = 0; k < pad; k++)
                line[len++] = CH_SPACE;

        n = (len > 64) ? 64 : len;
        for (int k = 0; k < n; k++)
            expected_text.push_back('{line[k], k == n - 1});
    endfunction

    task automatic add_case(input logic [63:0] mag, input logic neg, input logic [1:0] rsel,
                            input logic upper, input logic [6:0] fw, input logic [5:0] md,
                            input logic lj, input logic zp, input logic af, input string txt);
        number_case_t row;

        row.spec.magnitude      = mag;
        row.spec.is_negative    = neg;
        row.spec.radix_select   = rsel;
        row.spec.upper_case     = upper;
        row.spec.field_width    = fw;
        row.spec.min_digits     = md;
        row.spec.left_justify   = lj;
        row.spec.zero_pad       = zp;
        row.spec.alternate_form = af;
        row.text                = txt;
        number_cases.push_back(row);
    endtask

    // Text receiver: changing stall patterns, plus one long hold-off that
    // backs the block up into its input.
    initial
    begin
        int cycle;
        int hold;

        cycle = 0;
        hold  = 0;
        text_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cycle++;
            if (cycle == 1500)
                hold = 600;
            if (hold > 0)
            begin
                hold--;
                text_if.ready <= 1'b0;
            end
            else
            begin
                case ((cycle / 256) % 4)
                    0: text_if.ready <= 1'b1;
                    1: text_if.ready <= ($urandom_range(0, 9) < 7);
                    2: text_if.ready <= (cycle % 5 != 0);
                    default: text_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        text_char_t want;

        if (rst_n && text_if.valid && text_if.ready)
        begin
            if (expected_text.size() == 0)
                report_mismatch($sformatf("unexpected character 0x%02h", text_if.out_char));
            else
            begin
                want = expected_text.pop_front();
                if (text_if.out_char !== want.ch)
                    report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                              text_if.out_char, want.ch));
                if (text_if.last_char !== want.last)
                    report_mismatch($sformatf("last_char %b, expected %b",
                                              text_if.last_char, want.last));
            end
        end
    end

    initial
    begin
        number_case_t row;
        ittf_item_t   spec;
        int           burst_left;
        int           gap;

        mismatch_count = 0;
        number_if.valid = 1'b0;
        {number_if.magnitude, number_if.is_negative, number_if.radix_select,
         number_if.upper_case, number_if.field_width, number_if.min_digits,
         number_if.left_justify, number_if.zero_pad, number_if.alternate_form} = ittf_item_t'(0);
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: an empty text means the predictor supplies the result.
        add_case(64'd0, 0, RADIX_DEC, 0, 0, 0, 0, 0, 0, "0");
        add_case(64'd0, 0, RADIX_OCT, 0, 0, 0, 0, 0, 1, "0");
        add_case(64'd0, 0, RADIX_HEX, 0, 0, 0, 0, 0, 1, "0x0");
        add_case(64'd0, 1, RADIX_DEC, 0, 0, 0, 0, 0, 0, "-0");
        add_case('1, 0, RADIX_HEX, 1, 0, 0, 0, 0, 1, "0XFFFFFFFFFFFFFFFF");
        add_case('1, 0, RADIX_HEX, 0, 0, 0, 0, 0, 0, "ffffffffffffffff");
        add_case('1, 0, RADIX_DEC, 0, 0, 0, 0, 0, 1, "18446744073709551615");
        add_case('1, 0, RADIX_OCT, 0, 0, 0, 0, 0, 1, "01777777777777777777777");
        add_case(64'd42, 1, RADIX_DEC, 0, 6, 0, 0, 0, 0, "   -42");
        add_case(64'd42, 1, RADIX_DEC, 0, 6, 0, 0, 1, 0, "-00042");
        add_case(64'd42, 0, RADIX_DEC, 0, 6, 0, 1, 1, 0, "42    ");
        add_case(64'd255, 0, RADIX_UNUSED, 1, 0, 0, 0, 0, 1, "255");
        add_case(64'd8, 0, RADIX_OCT, 0, 0, 0, 0, 0, 1, "010");
        add_case(64'd8, 0, RADIX_OCT, 0, 0, 4, 0, 0, 1, "0010");
        add_case(64'd7, 0, RADIX_DEC, 0, 0, 0, 0, 0, 1, "7");
        add_case(64'd5, 0, RADIX_DEC, 0, 0, 63, 0, 0, 0, "");
        add_case(64'd1, 0, RADIX_DEC, 0, 127, 0, 0, 0, 0, "");
        add_case(64'd1, 0, RADIX_HEX, 0, 127, 32, 0, 1, 1, "");
        add_case(64'h00AB_CDEF, 1, RADIX_HEX, 1, 64, 32, 1, 0, 1, "");
        add_case(64'h00AB_CDEF, 0, RADIX_HEX, 0, 20, 9, 0, 0, 1, "");
        add_case('1, 1, RADIX_OCT, 0, 64, 0, 0, 1, 1, "");
        add_case('1, 0, RADIX_DEC, 0, 0, 32, 0, 0, 0, "");
        add_case(64'h8000_0000_0000_0000, 1, RADIX_OCT, 1, 40, 25, 1, 1, 0, "");

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 3))
                0: spec.magnitude = 64'($urandom_range(0, 1000));
                1: spec.magnitude = {$urandom, $urandom};
                2: spec.magnitude = $urandom_range(0, 1) ? (64'd1 << $urandom_range(0, 63))
                                                         : ('1 >> $urandom_range(0, 63));
                default: spec.magnitude = $urandom_range(0, 1) ? 64'd0 : '1;
            endcase
            spec.is_negative    = 1'($urandom);
            spec.radix_select   = 2'($urandom);
            spec.upper_case     = 1'($urandom);
            spec.field_width    = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 40))
                                                            : 7'($urandom_range(0, 127));
            spec.min_digits     = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 24))
                                                            : 6'($urandom_range(0, 63));
            spec.left_justify   = 1'($urandom);
            spec.zero_pad       = 1'($urandom);
            spec.alternate_form = 1'($urandom);
            number_cases.push_back('{spec, ""});
        end

        burst_left = $urandom_range(1, 12);
        foreach (number_cases[i])
        begin
            row = number_cases[i];
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 15);
                @(negedge clk);
                number_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                // Now and then a long burst with no idling at all.
                burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            end
            burst_left--;
            @(negedge clk);
            {number_if.magnitude, number_if.is_negative, number_if.radix_select,
             number_if.upper_case, number_if.field_width, number_if.min_digits,
             number_if.left_justify, number_if.zero_pad,
             number_if.alternate_form} <= row.spec;
            number_if.valid <= 1'b1;
            do
                @(posedge clk);
            while (!number_if.ready);
            if (row.text.len() == 0)
                format_text(row.spec);
            else
                for (int k = 0; k < row.text.len(); k++)
                    expected_text.push_back('{8'(row.text[k]), k == row.text.len() - 1});
        end
        @(negedge clk);
        number_if.valid <= 1'b0;

        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("** integer_to_text_formatter_unit: PASSED **");
        else
            $display("** integer_to_text_formatter_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #16_000_000;
        $display("Timeout with %0d characters outstanding", expected_text.size());
        $display("** integer_to_text_formatter_unit: FAILED **");
        $finish;
    end

endmodule
